/* rtl/moldudp64_packet_boundary_planner_macros.svh */
// Assertion macros shared by the packet boundary planner modules.
// Included by each RTL file that carries concurrent assertions; no other dependencies.
`ifndef MOLDUDP64_PACKET_BOUNDARY_PLANNER_MACROS_SVH
`define MOLDUDP64_PACKET_BOUNDARY_PLANNER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define MDPBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MDPBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mdpbp_pkg.sv */
// Package for the packet boundary planner: constants, result kinds and the plan record.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps

package mdpbp_pkg;

    // Fixed header and protocol constants.
    localparam logic [15:0] HDR_BYTES       = 16'd20;
    localparam logic [17:0] PREFIX_HDR      = 18'd22;
    localparam logic [16:0] PREFIX_BYTES    = 17'd2;
    localparam logic [15:0] COUNT_LIMIT     = 16'd65534;
    localparam logic [15:0] EOS_COUNT       = 16'hFFFF;
    localparam logic [15:0] MIN_TS_LEN      = 16'd11;
    localparam logic [15:0] MAX_BYTES_RESET = 16'd1400;

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 48;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HB_INTERVAL = 8'd1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_HEARTBEAT = 2'd1,
        KIND_END       = 2'd2,
        KIND_OVERSIZE  = 2'd3
    } t_kind;

    // One closed data packet.
    typedef struct packed {
        logic [63:0] seq;
        logic [15:0] count;
        logic [15:0] bytes;
    } t_close;

    // Everything one accepted item produces, in output order:
    // mask bit 0 is the close before the message, bit 1 the close before
    // a heartbeat, bit 2 the closing heartbeat, end or oversize result.
    typedef struct packed {
        logic [2:0]  mask;
        t_close      fit_close;
        t_close      hb_close;
        t_kind       tail_kind;
        logic [63:0] tail_seq;
    } t_plan;

endpackage

/* rtl/moldudp64_packet_boundary_planner.sv */
// Path: an accepted item's plan is written to the plan queue, then its results to the output register.
// Throughput: one item per cycle while the plan queue has room; items with no result never
// occupy it. Results leave the output register one per cycle unless stalled, up to three per item.
// Reset (synchronous, active low) restores the limit 1400, disables heartbeats, sets the
// next sequence to 1, empties the open packet and the queue, and clears the halt.
`timescale 1ns / 1ps

module moldudp64_packet_boundary_planner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [15:0]                        i_msg_length,
    input  logic [47:0]                        i_msg_timestamp,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_packet_kind,
    output logic [63:0]                        o_first_sequence,
    output logic [15:0]                        o_message_count,
    output logic [15:0]                        o_packet_bytes,
    output logic                               o_last_of_run,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mdpbp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mdpbp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mdpbp_pkg::*;

    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;
    t_plan plan;
    t_plan head;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Front: classifies each item and updates the packing state.
    mdpbp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_msg_length    (i_msg_length),
        .i_msg_timestamp (i_msg_timestamp),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_plan          (plan)
    );

    // Queue of plans that still have results to send.
    mdpbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (plan),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    // Back: sends the results of each plan in order.
    mdpbp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (queue_empty),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_packet_kind    (o_packet_kind),
        .o_first_sequence (o_first_sequence),
        .o_message_count  (o_message_count),
        .o_packet_bytes   (o_packet_bytes),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

/* rtl/mdpbp_front.sv */
// Front part of the planner: configuration registers, packing state and item classification.
// Depends on mdpbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "moldudp64_packet_boundary_planner_macros.svh"

module mdpbp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [15:0]                        i_msg_length,
    input  logic [47:0]                        i_msg_timestamp,
    input  logic                               i_cfg_valid,
    input  logic [mdpbp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mdpbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_queue_full,
    output logic                               o_push,
    output mdpbp_pkg::t_plan                   o_plan
);
    import mdpbp_pkg::*;

    // Configuration and packing state.
    logic [15:0] r_max_bytes,  n_max_bytes;
    logic [47:0] r_hb_interval, n_hb_interval;
    logic [15:0] r_bytes_used, n_bytes_used;
    logic [15:0] r_open_count, n_open_count;
    logic [63:0] r_next_seq,   n_next_seq;
    logic [63:0] r_end_seq,    n_end_seq;
    logic [47:0] r_last_hb,    n_last_hb;
    logic [48:0] r_deadline,   n_deadline;
    logic        r_halted,     n_halted;

    logic        accept;
    logic [16:0] need;
    logic        oversize;
    logic        fit_close;
    logic        has_open;
    logic [15:0] bu1;
    logic [15:0] oc1;
    logic [63:0] ns1;
    logic [15:0] bu2;
    logic [15:0] oc2;
    logic [63:0] end2;
    logic        hb_en;
    logic        armed;
    logic        fire;
    logic        hb_update;
    t_plan       plan;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    // Fit checks against the limit; the end sequence tracks next_seq plus open count.
    assign need      = {1'b0, i_msg_length} + PREFIX_BYTES;
    assign oversize  = ({2'b00, i_msg_length} + PREFIX_HDR) > {2'b00, r_max_bytes};
    assign fit_close = (({1'b0, r_bytes_used} + need) > {1'b0, r_max_bytes})
                       || (r_open_count == COUNT_LIMIT);
    assign has_open  = (r_open_count != 16'd0);
    assign bu1       = fit_close ? HDR_BYTES : r_bytes_used;
    assign oc1       = fit_close ? 16'd0 : r_open_count;
    assign ns1       = fit_close ? r_end_seq : r_next_seq;
    assign bu2       = bu1 + need[15:0];
    assign oc2       = oc1 + 16'd1;
    assign end2      = r_end_seq + 64'd1;

    // Heartbeat decision; the deadline register holds last heartbeat time plus interval.
    assign hb_en     = (r_hb_interval != 48'd0) && (i_msg_length >= MIN_TS_LEN);
    assign armed     = (r_last_hb != 48'd0);
    assign fire      = hb_en && armed
                       && ((i_msg_timestamp < r_last_hb)
                           || ({1'b0, i_msg_timestamp} >= r_deadline));
    assign hb_update = hb_en && (!armed || fire);

    // Build the plan record for the accepted item.
    always_comb begin
        plan.mask      = 3'b000;
        plan.fit_close = '{seq: r_next_seq, count: r_open_count, bytes: r_bytes_used};
        plan.hb_close  = '{seq: ns1, count: oc2, bytes: bu2};
        plan.tail_kind = KIND_DATA;
        plan.tail_seq  = r_next_seq;
        if (i_req_type) begin
            plan.mask      = {1'b1, 1'b0, has_open};
            plan.tail_kind = KIND_END;
            plan.tail_seq  = r_end_seq;
        end else if (oversize) begin
            plan.mask      = 3'b100;
            plan.tail_kind = KIND_OVERSIZE;
        end else begin
            plan.mask      = {fire, fire, fit_close && has_open};
            plan.tail_kind = KIND_HEARTBEAT;
            plan.tail_seq  = end2;
        end
    end

    assign o_plan = plan;
    assign o_push = accept && !r_halted && (plan.mask != 3'b000);

    // Next state for an accepted item, then any configuration write.
    always_comb begin
        n_max_bytes   = r_max_bytes;
        n_hb_interval = r_hb_interval;
        n_bytes_used  = r_bytes_used;
        n_open_count  = r_open_count;
        n_next_seq    = r_next_seq;
        n_end_seq     = r_end_seq;
        n_last_hb     = r_last_hb;
        n_deadline    = r_deadline;
        n_halted      = r_halted;
        if (accept && !r_halted) begin
            if (i_req_type || oversize) begin
                n_halted = 1'b1;
            end else begin
                n_end_seq = end2;
                if (fire) begin
                    n_next_seq   = end2;
                    n_bytes_used = HDR_BYTES;
                    n_open_count = 16'd0;
                end else begin
                    n_next_seq   = ns1;
                    n_bytes_used = bu2;
                    n_open_count = oc2;
                end
                if (hb_update) begin
                    n_last_hb  = i_msg_timestamp;
                    n_deadline = {1'b0, i_msg_timestamp} + {1'b0, r_hb_interval};
                end
            end
        end
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_BYTES: begin
                    n_max_bytes = i_cfg_data[15:0];
                end
                REG_HB_INTERVAL: begin
                    n_hb_interval = i_cfg_data;
                    n_deadline    = {1'b0, r_last_hb} + {1'b0, i_cfg_data};
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes   <= MAX_BYTES_RESET;
            r_hb_interval <= 48'd0;
            r_bytes_used  <= HDR_BYTES;
            r_open_count  <= 16'd0;
            r_next_seq    <= 64'd1;
            r_end_seq     <= 64'd1;
            r_last_hb     <= 48'd0;
            r_deadline    <= 49'd0;
            r_halted      <= 1'b0;
        end else begin
            r_max_bytes   <= n_max_bytes;
            r_hb_interval <= n_hb_interval;
            r_bytes_used  <= n_bytes_used;
            r_open_count  <= n_open_count;
            r_next_seq    <= n_next_seq;
            r_end_seq     <= n_end_seq;
            r_last_hb     <= n_last_hb;
            r_deadline    <= n_deadline;
            r_halted      <= n_halted;
        end
    end

    // A halted block queues nothing, and a terminal result always halts it.
    `MDPBP_ASSERT_IMPL(a_no_push_halted, i_clk, i_rst_n, r_halted, !o_push, "push while halted")
    `MDPBP_ASSERT_NEXT(a_tail_halts, i_clk, i_rst_n, o_push && o_plan.mask[2] && (o_plan.tail_kind == KIND_END || o_plan.tail_kind == KIND_OVERSIZE), r_halted, "terminal result did not halt")

endmodule

/* rtl/mdpbp_queue.sv */
// Short queue of plan records between the front and back parts.
// Depends on mdpbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "moldudp64_packet_boundary_planner_macros.svh"

module mdpbp_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mdpbp_pkg::t_plan i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output mdpbp_pkg::t_plan o_head
);
    import mdpbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_plan            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `MDPBP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "queue overflow")
    `MDPBP_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue underflow")

endmodule

/* rtl/mdpbp_back.sv */
// Back part of the planner: expands each queued plan into result items, one per cycle unless the output stalls.
// Depends on mdpbp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "moldudp64_packet_boundary_planner_macros.svh"

module mdpbp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  mdpbp_pkg::t_plan i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_packet_kind,
    output logic [63:0]      o_first_sequence,
    output logic [15:0]      o_message_count,
    output logic [15:0]      o_packet_bytes,
    output logic             o_last_of_run
);
    import mdpbp_pkg::*;

    logic [2:0]  r_done, n_done;
    logic        r_out_valid, n_out_valid;
    t_kind       r_kind;
    logic [63:0] r_seq;
    logic [15:0] r_count;
    logic [15:0] r_bytes;
    logic        r_last;

    logic [2:0]  pending;
    logic [2:0]  pick;
    logic        last;
    logic        out_free;
    logic        emit;
    t_kind       sel_kind;
    logic [63:0] sel_seq;
    logic [15:0] sel_count;
    logic [15:0] sel_bytes;

    // Results of the head entry not yet sent; the lowest one goes next.
    assign pending  = i_empty ? 3'b000 : (i_head.mask & ~r_done);
    assign pick     = pending & (~pending + 3'b001);
    assign last     = ((pending & ~pick) == 3'b000);
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = out_free && (pending != 3'b000);
    assign o_pop    = emit && last;

    // Field selection for the chosen result.
    always_comb begin
        sel_kind  = KIND_DATA;
        sel_seq   = i_head.fit_close.seq;
        sel_count = i_head.fit_close.count;
        sel_bytes = i_head.fit_close.bytes;
        case (pick)
            3'b001: begin
                sel_kind = KIND_DATA;
            end
            3'b010: begin
                sel_kind  = KIND_DATA;
                sel_seq   = i_head.hb_close.seq;
                sel_count = i_head.hb_close.count;
                sel_bytes = i_head.hb_close.bytes;
            end
            default: begin
                sel_kind = i_head.tail_kind;
                sel_seq  = i_head.tail_seq;
                case (i_head.tail_kind)
                    KIND_HEARTBEAT: begin
                        sel_count = 16'd0;
                        sel_bytes = HDR_BYTES;
                    end
                    KIND_END: begin
                        sel_count = EOS_COUNT;
                        sel_bytes = HDR_BYTES;
                    end
                    default: begin
                        sel_count = 16'd0;
                        sel_bytes = 16'd0;
                    end
                endcase
            end
        endcase
    end

    // Progress through the entry and output register valid.
    always_comb begin
        n_done      = r_done;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = emit;
        end
        if (emit) begin
            n_done = last ? 3'b000 : (r_done | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 3'b000;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= sel_kind;
            r_seq   <= sel_seq;
            r_count <= sel_count;
            r_bytes <= sel_bytes;
            r_last  <= last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_packet_kind    = r_kind;
    assign o_first_sequence = r_seq;
    assign o_message_count  = r_count;
    assign o_packet_bytes   = r_bytes;
    assign o_last_of_run    = r_last;

    // Retiring an entry always presents its final result next.
    `MDPBP_ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, o_pop, o_out_valid && o_last_of_run, "entry retired without final result")

endmodule
